// ----- hw/rtl/cau_pkg.sv -----
// cau_pkg: shared types, command codes, status codes and helper functions
// for the complex arithmetic unit. No dependencies.
package cau_pkg;

   // command codes of a request
   typedef enum logic [2:0] {
      CMD_ADD   = 3'd0,
      CMD_SUB   = 3'd1,
      CMD_MUL   = 3'd2,
      CMD_DIV   = 3'd3,
      CMD_POLAR = 3'd4,
      CMD_POWER = 3'd5,
      CMD_MOD   = 3'd6,
      CMD_CONJ  = 3'd7
   } cmd_type;

   // work class chosen by the front end
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0,
      CLS_MUL    = 2'd1,
      CLS_DIV    = 2'd2,
      CLS_RAD    = 2'd3
   } cls_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIVZERO  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic signed [31:0] Q_ONE   = 32'sd65536;
   localparam logic signed [31:0] Q_ZERO  = 32'sd0;
   localparam logic signed [31:0] PI_Q    = 32'sd205887;
   localparam logic signed [31:0] MAX_Q   = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MIN_Q   = 32'sh80000000;
   localparam logic signed [64:0] MAX_W   = 65'sd2147483647;
   localparam logic signed [64:0] MIN_W   = -65'sd2147483648;
   localparam int CORDIC_STEPS = 16;

   // one queued request after classification
   typedef struct packed {
      cmd_type            command;
      cls_type            cls;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
      logic [3:0]         exponent;
   } entry_type;

   // arctangent of 2^-i in Q16.16
   function automatic logic signed [31:0] atan_q(input logic [3:0] i);
      logic signed [31:0] v;
      case (i)
         4'd0:    v = 32'sd51472;
         4'd1:    v = 32'sd30386;
         4'd2:    v = 32'sd16055;
         4'd3:    v = 32'sd8150;
         4'd4:    v = 32'sd4091;
         4'd5:    v = 32'sd2047;
         4'd6:    v = 32'sd1024;
         4'd7:    v = 32'sd512;
         4'd8:    v = 32'sd256;
         4'd9:    v = 32'sd128;
         4'd10:   v = 32'sd64;
         4'd11:   v = 32'sd32;
         4'd12:   v = 32'sd16;
         4'd13:   v = 32'sd8;
         4'd14:   v = 32'sd4;
         default: v = 32'sd2;
      endcase
      return v;
   endfunction

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat_val(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > MAX_W) r = MAX_Q;
      else if (v < MIN_W) r = MIN_Q;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic sat_ovf(input logic signed [64:0] v);
      return (v > MAX_W) || (v < MIN_W);
   endfunction

endpackage

// ----- hw/rtl/cau_channels.sv -----
// cau_channels: request and response channel interfaces of the complex
// arithmetic unit. Depends on nothing.
interface cau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;
   logic [3:0]         exponent;

   modport source(output valid, command, a_re, a_im, b_re, b_im, exponent,
                  input ready);
   modport sink(input valid, command, a_re, a_im, b_re, b_im, exponent,
                output ready);
endinterface

interface cau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_re;
   logic signed [31:0] result_im;
   logic [1:0]         status;

   modport source(output valid, result_re, result_im, status, input ready);
   modport sink(input valid, result_re, result_im, status, output ready);
endinterface

// ----- hw/rtl/cau_front.sv -----
// cau_front: accepts requests, classifies them and holds them in a
// two-entry queue. Depends on cau_pkg and cau_channels.
module cau_front import cau_pkg::*; #(
   parameter int MAX_EXPONENT = 15
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_ch,
   output entry_type q_entry,
   output logic      q_valid,
   input  logic      q_pop
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   entry_type  new_entry;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (cnt_ff != 2'd0);
   assign q_entry      = mem_ff[rd_ptr_ff];

   // classify the incoming request and clamp the exponent
   always_comb begin
      new_entry.command  = cmd_type'(req_ch.command);
      new_entry.a_re     = req_ch.a_re;
      new_entry.a_im     = req_ch.a_im;
      new_entry.b_re     = req_ch.b_re;
      new_entry.b_im     = req_ch.b_im;
      new_entry.exponent = ({28'b0, req_ch.exponent} > MAX_EXPONENT) ?
                           4'(MAX_EXPONENT) : req_ch.exponent;
      case (cmd_type'(req_ch.command))
         CMD_MUL, CMD_POWER:  new_entry.cls = CLS_MUL;
         CMD_DIV:             new_entry.cls = CLS_DIV;
         CMD_POLAR, CMD_MOD:  new_entry.cls = CLS_RAD;
         default:             new_entry.cls = CLS_SIMPLE;
      endcase
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= new_entry;
   end

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !q_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (!push && q_pop) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

// ----- hw/rtl/cau_back.sv -----
// cau_back: sequencer that executes queued requests with one shared
// multiplier, a restoring divider, a square root unit and a CORDIC.
// Depends on cau_pkg and cau_channels.
module cau_back import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type q_entry,
   input  logic      q_valid,
   output logic      q_pop,
   cau_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_MSAT, S_DSET, S_DIV, S_DEND,
      S_SQSET, S_SQRT, S_SQEND, S_CSET, S_CORD, S_FIN
   } state_type;

   state_type          state_ff;
   entry_type          op_ff;
   logic signed [31:0] cr_ff, ci_ff;
   logic               ov_ff, dz_ff;
   logic [2:0]         k_ff;
   logic [4:0]         it_ff;
   logic [3:0]         cnt_ff;
   logic signed [64:0] acc_re_ff, acc_im_ff;
   logic [63:0]        d_ff;
   logic signed [63:0] prod_ff;
   logic               part_ff, neg_ff, big_ff;
   logic [63:0]        rem_ff;
   logic [31:0]        low_ff, q_ff;
   logic [63:0]        sq_src_ff;
   logic [33:0]        sq_rem_ff;
   logic [31:0]        root_ff;
   logic signed [35:0] x_ff, y_ff;
   logic signed [31:0] z_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_re_ff, rsp_im_ff;
   logic [1:0]         rsp_st_ff;

   logic signed [31:0] mul_a, mul_b, y_re, y_im;
   logic signed [63:0] mul_p;
   logic signed [64:0] pe, ps;
   logic signed [64:0] acc_re_in, acc_im_in;
   logic [63:0]        d_in;
   logic [2:0]         np, j;
   logic signed [64:0] s_re, s_im;
   logic signed [64:0] m_sel;
   logic [63:0]        m_mag;
   logic               big;
   logic [64:0]        dt, ddiff;
   logic               dge;
   logic signed [31:0] dval;
   logic               dovf;
   logic [35:0]        st, strial;
   logic               sge;
   logic [3:0]         sh;
   logic signed [35:0] xs, ys, nx, ny;
   logic signed [31:0] nz;
   logic [1:0]         status_w;

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result_re = rsp_re_ff;
   assign rsp_ch.result_im = rsp_im_ff;
   assign rsp_ch.status    = rsp_st_ff;
   assign status_w = dz_ff ? ST_DIVZERO : (ov_ff ? ST_OVERFLOW : ST_OK);

   // shared multiplier operand selection and product accumulation
   always_comb begin
      y_re = (op_ff.command == CMD_POWER) ? op_ff.a_re : op_ff.b_re;
      y_im = (op_ff.command == CMD_POWER) ? op_ff.a_im : op_ff.b_im;
      mul_a = Q_ZERO;
      mul_b = Q_ZERO;
      np = 3'd2;
      case (op_ff.cls)
         CLS_MUL: begin
            np = 3'd4;
            case (k_ff)
               3'd0:    begin mul_a = cr_ff; mul_b = y_re; end
               3'd1:    begin mul_a = ci_ff; mul_b = y_im; end
               3'd2:    begin mul_a = cr_ff; mul_b = y_im; end
               default: begin mul_a = ci_ff; mul_b = y_re; end
            endcase
         end
         CLS_DIV: begin
            np = 3'd6;
            case (k_ff)
               3'd0:    begin mul_a = op_ff.b_re; mul_b = op_ff.b_re; end
               3'd1:    begin mul_a = op_ff.b_im; mul_b = op_ff.b_im; end
               3'd2:    begin mul_a = op_ff.a_re; mul_b = op_ff.b_re; end
               3'd3:    begin mul_a = op_ff.a_im; mul_b = op_ff.b_im; end
               3'd4:    begin mul_a = op_ff.a_im; mul_b = op_ff.b_re; end
               default: begin mul_a = op_ff.a_re; mul_b = op_ff.b_im; end
            endcase
         end
         default: begin
            if (k_ff == 3'd0) begin
               mul_a = op_ff.a_re; mul_b = op_ff.a_re;
            end else begin
               mul_a = op_ff.a_im; mul_b = op_ff.a_im;
            end
         end
      endcase
      mul_p = mul_a * mul_b;

      pe = {prod_ff[63], prod_ff};
      ps = pe >>> 16;
      j  = k_ff - 3'd1;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      d_in      = d_ff;
      if (k_ff != 3'd0) begin
         case (op_ff.cls)
            CLS_MUL: begin
               case (j)
                  3'd0:    acc_re_in = acc_re_ff + ps;
                  3'd1:    acc_re_in = acc_re_ff - ps;
                  default: acc_im_in = acc_im_ff + ps;
               endcase
            end
            CLS_DIV: begin
               case (j)
                  3'd0, 3'd1: d_in = d_ff + prod_ff;
                  3'd2, 3'd3: acc_re_in = acc_re_ff + pe;
                  3'd4:       acc_im_in = acc_im_ff + pe;
                  default:    acc_im_in = acc_im_ff - pe;
               endcase
            end
            default: d_in = d_ff + prod_ff;
         endcase
      end
   end

   // add, subtract and conjugate on the queue head
   always_comb begin
      if (q_entry.command == CMD_SUB) begin
         s_re = 65'(q_entry.a_re) - 65'(q_entry.b_re);
         s_im = 65'(q_entry.a_im) - 65'(q_entry.b_im);
      end else if (q_entry.command == CMD_CONJ) begin
         s_re = 65'(q_entry.a_re);
         s_im = -65'(q_entry.a_im);
      end else begin
         s_re = 65'(q_entry.a_re) + 65'(q_entry.b_re);
         s_im = 65'(q_entry.a_im) + 65'(q_entry.b_im);
      end
   end

   // divider setup, step and result
   always_comb begin
      m_sel = part_ff ? acc_im_ff : acc_re_ff;
      m_mag = m_sel[64] ? 64'(-m_sel) : m_sel[63:0];
      big   = {16'b0, m_mag} >= {d_ff, 16'b0};
      dt    = {rem_ff, low_ff[31]};
      dge   = dt >= {1'b0, d_ff};
      ddiff = dt - {1'b0, d_ff};
      dovf  = 1'b0;
      if (big_ff) begin
         dovf = 1'b1;
         dval = neg_ff ? MIN_Q : MAX_Q;
      end else if (neg_ff) begin
         if (q_ff > 32'h80000000) begin
            dovf = 1'b1;
            dval = MIN_Q;
         end else begin
            dval = $signed(32'd0 - q_ff);
         end
      end else if (q_ff[31]) begin
         dovf = 1'b1;
         dval = MAX_Q;
      end else begin
         dval = $signed(q_ff);
      end
   end

   // square root digit step
   always_comb begin
      st     = {sq_rem_ff, sq_src_ff[63:62]};
      strial = {2'b0, root_ff, 2'b01};
      sge    = st >= strial;
   end

   // cordic vectoring step
   always_comb begin
      sh = it_ff[3:0];
      xs = x_ff >>> sh;
      ys = y_ff >>> sh;
      nx = x_ff;
      ny = y_ff;
      nz = z_ff;
      if (y_ff > 36'sd0) begin
         nx = x_ff + ys;
         ny = y_ff - xs;
         nz = z_ff + atan_q(sh);
      end else if (y_ff < 36'sd0) begin
         nx = x_ff - ys;
         ny = y_ff + xs;
         nz = z_ff - atan_q(sh);
      end
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready && state_ff != S_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  op_ff     <= q_entry;
                  ov_ff     <= (q_entry.cls == CLS_SIMPLE) &&
                               (sat_ovf(s_re) || sat_ovf(s_im));
                  dz_ff     <= 1'b0;
                  k_ff      <= 3'd0;
                  acc_re_ff <= '0;
                  acc_im_ff <= '0;
                  d_ff      <= '0;
                  part_ff   <= 1'b0;
                  case (q_entry.cls)
                     CLS_SIMPLE: begin
                        cr_ff    <= sat_val(s_re);
                        ci_ff    <= sat_val(s_im);
                        state_ff <= S_FIN;
                     end
                     CLS_MUL: begin
                        if (q_entry.command == CMD_POWER) begin
                           cr_ff  <= Q_ONE;
                           ci_ff  <= Q_ZERO;
                           cnt_ff <= q_entry.exponent;
                           state_ff <= (q_entry.exponent == 4'd0) ? S_FIN : S_PROD;
                        end else begin
                           cr_ff    <= q_entry.a_re;
                           ci_ff    <= q_entry.a_im;
                           cnt_ff   <= 4'd1;
                           state_ff <= S_PROD;
                        end
                     end
                     default: state_ff <= S_PROD;
                  endcase
               end
            end
            S_PROD: begin
               if (k_ff < np) prod_ff <= mul_p;
               acc_re_ff <= acc_re_in;
               acc_im_ff <= acc_im_in;
               d_ff      <= d_in;
               if (k_ff == np) begin
                  case (op_ff.cls)
                     CLS_MUL: state_ff <= S_MSAT;
                     CLS_DIV: state_ff <= S_DSET;
                     default: state_ff <= S_SQSET;
                  endcase
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end
            S_MSAT: begin
               cr_ff <= sat_val(acc_re_ff);
               ci_ff <= sat_val(acc_im_ff);
               if (sat_ovf(acc_re_ff) || sat_ovf(acc_im_ff)) ov_ff <= 1'b1;
               if (cnt_ff == 4'd1) begin
                  state_ff <= S_FIN;
               end else begin
                  cnt_ff    <= cnt_ff - 4'd1;
                  k_ff      <= 3'd0;
                  acc_re_ff <= '0;
                  acc_im_ff <= '0;
                  state_ff  <= S_PROD;
               end
            end
            S_DSET: begin
               if (d_ff == 64'd0) begin
                  dz_ff    <= 1'b1;
                  cr_ff    <= Q_ZERO;
                  ci_ff    <= Q_ZERO;
                  state_ff <= S_FIN;
               end else begin
                  neg_ff   <= m_sel[64];
                  big_ff   <= big;
                  rem_ff   <= {16'b0, m_mag[63:16]};
                  low_ff   <= {m_mag[15:0], 16'b0};
                  q_ff     <= 32'd0;
                  it_ff    <= 5'd0;
                  state_ff <= big ? S_DEND : S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= dge ? ddiff[63:0] : dt[63:0];
               q_ff   <= {q_ff[30:0], dge};
               low_ff <= {low_ff[30:0], 1'b0};
               it_ff  <= it_ff + 5'd1;
               if (it_ff == 5'd31) state_ff <= S_DEND;
            end
            S_DEND: begin
               if (dovf) ov_ff <= 1'b1;
               if (part_ff) begin
                  ci_ff    <= dval;
                  state_ff <= S_FIN;
               end else begin
                  cr_ff    <= dval;
                  part_ff  <= 1'b1;
                  state_ff <= S_DSET;
               end
            end
            S_SQSET: begin
               sq_src_ff <= d_ff;
               sq_rem_ff <= '0;
               root_ff   <= '0;
               it_ff     <= 5'd0;
               state_ff  <= S_SQRT;
            end
            S_SQRT: begin
               sq_rem_ff <= sge ? 34'(st - strial) : st[33:0];
               root_ff   <= {root_ff[30:0], sge};
               sq_src_ff <= {sq_src_ff[61:0], 2'b00};
               it_ff     <= it_ff + 5'd1;
               if (it_ff == 5'd31) state_ff <= S_SQEND;
            end
            S_SQEND: begin
               if (root_ff[31]) begin
                  ov_ff <= 1'b1;
                  cr_ff <= MAX_Q;
               end else begin
                  cr_ff <= $signed(root_ff);
               end
               ci_ff    <= Q_ZERO;
               state_ff <= (op_ff.command == CMD_POLAR) ? S_CSET : S_FIN;
            end
            S_CSET: begin
               // left half plane: fold by pi first
               if (op_ff.a_re < 32'sd0) begin
                  x_ff <= -36'(op_ff.a_re);
                  y_ff <= -36'(op_ff.a_im);
                  z_ff <= (op_ff.a_im < 32'sd0) ? -PI_Q : PI_Q;
               end else begin
                  x_ff <= 36'(op_ff.a_re);
                  y_ff <= 36'(op_ff.a_im);
                  z_ff <= Q_ZERO;
               end
               it_ff    <= 5'd0;
               state_ff <= S_CORD;
            end
            S_CORD: begin
               x_ff  <= nx;
               y_ff  <= ny;
               z_ff  <= nz;
               it_ff <= it_ff + 5'd1;
               if (it_ff == 5'(CORDIC_STEPS - 1)) begin
                  ci_ff    <= nz;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_re_ff    <= cr_ff;
                  rsp_im_ff    <= ci_ff;
                  rsp_st_ff    <= status_w;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// complex_arithmetic_unit: Q16.16 complex add, sub, mul, div, polar, power,
// modulus and conjugate. Power does one complex multiply per exponent step;
// divide runs two 32-step restoring divisions (an overflowing quotient
// skips the division steps); modulus and polar run a 32-step square root,
// and polar then runs 16 CORDIC steps. One request is in work at a time;
// a two-entry queue takes requests meanwhile.
// Synchronous active-high reset empties the queue and the response register.
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int MAX_EXPONENT = 15
) (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);

   entry_type q_entry;
   logic      q_valid;
   logic      q_pop;

   // request intake and classification
   cau_front #(.MAX_EXPONENT(MAX_EXPONENT)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   // execution sequencer
   cau_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ----- verif/complex_arithmetic_unit_tb.sv -----
// complex_arithmetic_unit_tb: self-checking testbench for the Q16.16 complex
// arithmetic unit. Depends on cau_pkg, cau_channels and the unit itself.
`timescale 1ns / 100ps

// holds predicted responses and compares the responses of the unit
class cau_scoreboard;
   logic [65:0] pending_q[$];
   int          mismatches;

   // expected response of one request: {status, re, im}
   static function logic [65:0] predict_result(logic [2:0] cmd,
         logic signed [31:0] ar, logic signed [31:0] ai,
         logic signed [31:0] br, logic signed [31:0] bi, logic [3:0] n);
      longint rr, ri, d;
      bit ov, dz;
      int k;
      rr = 0; ri = 0; ov = 0; dz = 0;
      case (cmd)
         cau_pkg::CMD_ADD: begin
            rr = sat(longint'(ar) + br, ov);
            ri = sat(longint'(ai) + bi, ov);
         end
         cau_pkg::CMD_SUB: begin
            rr = sat(longint'(ar) - br, ov);
            ri = sat(longint'(ai) - bi, ov);
         end
         cau_pkg::CMD_MUL: cmul(ar, ai, br, bi, rr, ri, ov);
         cau_pkg::CMD_DIV: begin
            d = longint'(br) * br + longint'(bi) * bi;
            if (d == 0) dz = 1;
            else begin
               rr = qdiv(longint'(ar) * br, longint'(ai) * bi, d, ov);
               ri = qdiv(longint'(ai) * br, -(longint'(ar) * bi), d, ov);
            end
         end
         cau_pkg::CMD_POLAR: begin
            rr = radius(ar, ai, ov);
            ri = angle(ar, ai);
         end
         cau_pkg::CMD_POWER: begin
            rr = 65536; ri = 0;
            for (k = 0; k < n; k++) cmul(rr, ri, ar, ai, rr, ri, ov);
         end
         cau_pkg::CMD_MOD: rr = radius(ar, ai, ov);
         default: begin
            rr = ar;
            ri = sat(-longint'(ai), ov);
         end
      endcase
      return {dz ? cau_pkg::ST_DIVZERO : (ov ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK),
              rr[31:0], ri[31:0]};
   endfunction

   static function longint sat(longint v, inout bit ov);
      if (v > 64'sd2147483647) begin ov = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin ov = 1; return -64'sd2147483648; end
      return v;
   endfunction

   static function void cmul(longint ar, longint ai, longint br, longint bi,
                             output longint rr, output longint ri, inout bit ov);
      longint re, im;
      re = ((ar * br) >>> 16) - ((ai * bi) >>> 16);
      im = ((ar * bi) >>> 16) + ((ai * br) >>> 16);
      rr = sat(re, ov);
      ri = sat(im, ov);
   endfunction

   static function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin v -= res + b; res = (res >> 1) + b; end
         else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   static function longint radius(longint re, longint im, inout bit ov);
      longint unsigned r;
      r = isqrt(longint'(re * re) + longint'(im * im));
      if (r > 64'h7FFFFFFF) begin ov = 1; return 64'sd2147483647; end
      return r;
   endfunction

   static function longint qdiv(longint p1, longint p2, longint unsigned d,
                                inout bit ov);
      longint unsigned m1, m2, m, q, r;
      bit n1, n2, neg;
      int i;
      n1 = p1 < 0; n2 = p2 < 0;
      m1 = n1 ? -p1 : p1;
      m2 = n2 ? -p2 : p2;
      if (n1 == n2) begin m = m1 + m2; neg = n1; end
      else if (m1 >= m2) begin m = m1 - m2; neg = n1; end
      else begin m = m2 - m1; neg = n2; end
      q = m / d;
      if (q > 64'h8000) q = 64'h100000000;
      else begin
         r = m % d;
         for (i = 0; i < 16; i++) begin
            r <<= 1; q <<= 1;
            if (r >= d) begin r -= d; q |= 1; end
         end
      end
      if (neg) begin
         if (q > 64'h80000000) begin ov = 1; return -64'sd2147483648; end
         return -longint'(q);
      end
      if (q > 64'h7FFFFFFF) begin ov = 1; return 64'sd2147483647; end
      return q;
   endfunction

   static function longint angle(longint x, longint y);
      longint z, nx, ny;
      int i;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = y < 0 ? -longint'(cau_pkg::PI_Q) : longint'(cau_pkg::PI_Q);
         x = -x; y = -y;
      end
      for (i = 0; i < cau_pkg::CORDIC_STEPS; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i);
            z += cau_pkg::atan_q(4'(i));
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i);
            z -= cau_pkg::atan_q(4'(i));
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function void note_request(logic [2:0] cmd, logic [31:0] ar, logic [31:0] ai,
                              logic [31:0] br, logic [31:0] bi, logic [3:0] n);
      pending_q.push_back(predict_result(cmd, ar, ai, br, bi, n));
   endfunction

   function void check_response(logic [31:0] re, logic [31:0] im, logic [1:0] st);
      logic [65:0] exp_r;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response re=%h im=%h st=%0d",
                                        re, im, st);
         return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r !== {st, re, im}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                     exp_r[63:32], exp_r[31:0], exp_r[65:64], re, im, st);
      end
   endfunction
endclass

module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int N_RANDOM = 1750;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 0;
   logic reset = 1;
   cau_req_if req_ch();
   cau_rsp_if rsp_ch();
   cau_scoreboard sb = new();
   bit   stim_done = 0;
   bit   hold_rsp = 0;
   int   cycles = 0;

   complex_arithmetic_unit u_top(.clock(clock), .reset(reset),
                                 .req_ch(req_ch), .rsp_ch(rsp_ch));

   always #6 clock = ~clock;

   initial begin
      req_ch.valid = 0; req_ch.command = 0; req_ch.a_re = 0; req_ch.a_im = 0;
      req_ch.b_re = 0; req_ch.b_im = 0; req_ch.exponent = 0;
      rsp_ch.ready = 0;
   end

   // note accepted requests and check responses
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.command, req_ch.a_re, req_ch.a_im,
                         req_ch.b_re, req_ch.b_im, req_ch.exponent);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.result_re, rsp_ch.result_im, rsp_ch.status);
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[complex_arithmetic_unit] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 0;
         3: return $urandom;
         4: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         5: return $urandom_range(0, 32'h3FFFFFF) - 32'h2000000;
         default: return $urandom_range(0, 32'h3FFFFF) - 32'h200000;
      endcase
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(logic [2:0] cmd, logic [31:0] ar, logic [31:0] ai,
                               logic [31:0] br, logic [31:0] bi, logic [3:0] n,
                               int gap);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.command <= cmd;
      req_ch.a_re <= ar; req_ch.a_im <= ai; req_ch.b_re <= br; req_ch.b_im <= bi;
      req_ch.exponent <= n;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(int gap);
      logic [2:0] cmd;
      logic [31:0] br, bi;
      cmd = 3'($urandom_range(0, 7));
      br = pick_operand(); bi = pick_operand();
      if (cmd == CMD_DIV && $urandom_range(0, 9) == 0) begin br = 0; bi = 0; end
      send_request(cmd, pick_operand(), pick_operand(), br, bi,
                   4'($urandom_range(0, 15)), gap);
   endtask

   // response side readiness
   initial begin : rsp_side
      int w;
      @(negedge reset);
      forever begin
         w = (stim_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (hold_rsp) w = 0;
         if (w > 0 || hold_rsp) begin
            rsp_ch.ready <= 0;
            repeat (w) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // long hold-off on responses so the queue fills
   initial begin : rsp_holdoff
      @(negedge reset);
      repeat (400) @(posedge clock);
      hold_rsp = 1;
      repeat (600) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin : stimulus
      int i, tail;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed corners
      send_request(CMD_ADD, 32'h7FFFFFFF, 32'h80000000, 1, 32'hFFFFFFFF, 0, 0);
      send_request(CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 1, 32'hFFFFFFFF, 0, 0);
      send_request(CMD_MUL, 32'h00020000, 32'h00030000, 32'hFFFF0000, 32'h8000, 0, 0);
      send_request(CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0, 0);
      send_request(CMD_DIV, 32'h10000, 32'h10000, 0, 0, 0, 0);
      send_request(CMD_DIV, 32'h30000, 32'hFFFE0000, 32'h10000, 32'h10000, 0, 0);
      send_request(CMD_DIV, 32'h7FFFFFFF, 32'h80000000, 1, 0, 0, 0);
      send_request(CMD_DIV, 32'h80000000, 0, 32'hFFFFFFFF, 0, 0, 0);
      send_request(CMD_POLAR, 0, 0, 0, 0, 0, 0);
      send_request(CMD_POLAR, 32'hFFFF0000, 0, 0, 0, 0, 0);
      send_request(CMD_POLAR, 32'hFFFF0000, 32'hFFFF0000, 0, 0, 0, 0);
      send_request(CMD_POLAR, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
      send_request(CMD_POLAR, 32'h10000, 32'h7FFFFFFF, 0, 0, 0, 0);
      send_request(CMD_POWER, 32'h10000, 32'h10000, 0, 0, 0, 0);
      send_request(CMD_POWER, 32'h10000, 32'h10000, 0, 0, 15, 0);
      send_request(CMD_POWER, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 4, 0);
      send_request(CMD_MOD, 32'h30000, 32'h40000, 0, 0, 0, 0);
      send_request(CMD_MOD, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
      send_request(CMD_CONJ, 32'h12345678, 32'h80000000, 0, 0, 0, 0);
      send_request(CMD_CONJ, 32'h80000000, 32'h7FFFFFFF, 0, 0, 9, 0);
      // random part
      for (i = 0; i < N_RANDOM; i++)
         send_random(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
      req_ch.valid <= 0;
      stim_done = 1;
      tail = 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      while (tail < 200) begin @(posedge clock); tail++; end
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("[complex_arithmetic_unit] OK");
      else
         $display("[complex_arithmetic_unit] ERROR");
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/cau_pkg.sv
hw/rtl/cau_channels.sv
hw/rtl/cau_front.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_tb.sv
